// ===== hdl/kdms_pkg.sv =====
// kdms_pkg: shared field widths and types for the kd-tree median split block.
// No dependencies; imported by kd_max_variance_median_split (kdms_ram does not use it).
package kdms_pkg;
  localparam int COORD_W  = 16;
  localparam int ID_W     = 16;
  localparam int CFG_W    = 4;
  localparam int SDIM_W   = 3;
  localparam int MED_W    = 17;
  localparam int LOWC_W   = 6;
  localparam int IN_TW    = 32;
  localparam int OUT_TW   = 48;
  localparam int CFG_TW   = 8;
  localparam int DIM_RST  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [ID_W-1:0]    id_t;
  typedef logic signed [MED_W-1:0]   med_t;
endpackage

// ===== hdl/kdms_ram.sv =====
// kdms_ram: generic simple dual-port RAM, one write and one registered read port.
// No package dependencies.
module kdms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/kd_max_variance_median_split.sv =====
// kd_max_variance_median_split: one kd-tree node split over a loaded point set.
// Depends on kdms_pkg and kdms_ram (coordinate, id and slot stores).
//
// Usage:
//   in_*  : one coordinate word per cycle, point-major; tlast on the final
//           coordinate of the final point starts the split.
//   cfg_* : dim_count write, only while the block is idle; always ready.
//   out_* : one word per loaded point, ids in partitioned order, with the split
//           dimension, doubled median and low-side count; tlast on the final one.
// Throughput: loading takes one cycle per coordinate. After tlast the block is
//   not ready until all results are taken. The split runs on one shared
//   multiplier and single-port reads of the coordinate store: a variance
//   scan per dimension, the rank-count median, slot init and the two
//   partition passes with their swaps, then the result words, each held
//   until the receiver takes it.
// Reset: point count and coordinate index clear, dim_count returns to 2; the
//   stores need no clearing. A stalled receiver simply holds the output word.
module kd_max_variance_median_split import kdms_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // coord_value[15:0], point_id[31:16]
  input  logic              in_tlast,   // last_item
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // out_point_id, split_dim, split_value_x2, low_count
  output logic              out_tlast,  // last_out
  input  logic              cfg_tvalid,
  output logic              cfg_tready,
  input  logic [CFG_TW-1:0] cfg_tdata   // dim_count[3:0]
);
  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int DIMW  = $clog2(MAX_DIMS + 1);
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SW    = COORD_W + CNTW;
  localparam int QW    = 2 * COORD_W + CNTW;
  localparam int PRW   = SW + QW + 1;

  localparam logic [4:0] S_LOAD  = 5'd0,  S_FILL  = 5'd1,  S_VINIT = 5'd2,
                         S_VRD   = 5'd3,  S_VSQ   = 5'd4,  S_VACC  = 5'd5,
                         S_VN    = 5'd6,  S_VS2   = 5'd7,  S_VCMP  = 5'd8,
                         S_MINIT = 5'd9,  S_MRI   = 5'd10, S_MLI   = 5'd11,
                         S_MRJ   = 5'd12, S_MCJ   = 5'd13, S_MSEL  = 5'd14,
                         S_MMED  = 5'd15, S_SINIT = 5'd16, S_PST   = 5'd17,
                         S_LORD  = 5'd18, S_LOCRD = 5'd19, S_LOCMP = 5'd20,
                         S_HIRD  = 5'd21, S_HICRD = 5'd22, S_HICMP = 5'd23,
                         S_CHK   = 5'd24, S_SW2   = 5'd25, S_OINIT = 5'd26,
                         S_ORD   = 5'd27, S_OID   = 5'd28, S_OSET  = 5'd29,
                         S_OWAIT = 5'd30;

  logic [4:0]            state_r;
  logic [CFG_W-1:0]      dimcfg_r;
  logic [CNTW-1:0]       pc_r, n_r, i_r, j_r, lo_r, br1_r, br2_r, cnt_lt_r, cnt_le_r;
  logic signed [CNTW:0]  hi_r;
  logic [DW-1:0]         ci_r, fill_d_r, d_r, bd_r;
  logic signed [SW-1:0]  sum_r;
  logic signed [QW:0]    sumsq_r;
  logic signed [PRW-1:0] prod_r, t_r, best_r;
  coord_t                x_r, xi_r, mlo_r, mhi_r;
  med_t                  med2_r;
  logic                  pass_r;
  logic [PW-1:0]         sl_r, sh_r;
  logic                  out_valid_r, out_last_r;
  id_t                   out_id_r;
  logic [LOWC_W-1:0]     lowc_r;

  // dims in use
  logic [DIMW-1:0] dims;
  logic [DW-1:0]   dims_m1, c_sel;
  always_comb begin
    if (dimcfg_r == '0) dims = DIMW'(1);
    else if (32'(dimcfg_r) > MAX_DIMS) dims = DIMW'(MAX_DIMS);
    else dims = DIMW'(dimcfg_r);
    dims_m1 = DW'(dims - DIMW'(1));
    c_sel   = (ci_r >= dims_m1) ? dims_m1 : ci_r;
  end

  coord_t     in_coord;
  id_t        in_id;
  logic       in_acc, full, c_last;
  assign in_coord = coord_t'(in_tdata[COORD_W-1:0]);
  assign in_id    = in_tdata[COORD_W+ID_W-1:COORD_W];
  assign in_tready = (state_r == S_LOAD);
  assign in_acc   = in_tvalid && in_tready;
  assign full     = (32'(pc_r) >= MAX_POINTS);
  assign c_last   = (DIMW'(c_sel) + DIMW'(1) >= dims);

  // RAM ports
  logic          c_we, i_we, s_we;
  logic [AW-1:0] c_waddr, c_raddr;
  coord_t        c_wdata, c_rdata;
  logic [PW-1:0] s_waddr, s_wdata, s_raddr, s_rdata, i_raddr;
  id_t           i_rdata;
  logic [CNTW-1:0] n_m1;
  logic            lo_gt_hi;
  assign n_m1     = n_r - CNTW'(1);
  assign lo_gt_hi = $signed({1'b0, lo_r}) > hi_r;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = AW'(32'(pc_r[PW-1:0]) * MAX_DIMS + 32'(c_sel));
    c_wdata = in_coord;
    i_we    = 1'b0;
    if (state_r == S_LOAD && in_acc && !full) begin
      c_we = 1'b1;
      i_we = 1'b1;
    end else if (state_r == S_FILL) begin
      c_we    = 1'b1;
      c_waddr = AW'(32'(pc_r[PW-1:0]) * MAX_DIMS + 32'(fill_d_r));
      c_wdata = '0;
    end
    case (state_r) inside
      S_VRD:   c_raddr = AW'(32'(i_r[PW-1:0]) * MAX_DIMS + 32'(d_r));
      S_MRI:   c_raddr = AW'(32'(i_r[PW-1:0]) * MAX_DIMS + 32'(bd_r));
      S_MRJ:   c_raddr = AW'(32'(j_r[PW-1:0]) * MAX_DIMS + 32'(bd_r));
      S_LOCRD, S_HICRD: c_raddr = AW'(32'(s_rdata) * MAX_DIMS + 32'(bd_r));
      default: c_raddr = '0;
    endcase
    case (state_r)
      S_LORD:  s_raddr = lo_r[PW-1:0];
      S_HIRD:  s_raddr = hi_r[PW-1:0];
      default: s_raddr = i_r[PW-1:0];
    endcase
    s_we    = 1'b0;
    s_waddr = i_r[PW-1:0];
    s_wdata = i_r[PW-1:0];
    if (state_r == S_SINIT) begin
      s_we = 1'b1;
    end else if (state_r == S_CHK && !lo_gt_hi) begin
      s_we    = 1'b1;
      s_waddr = lo_r[PW-1:0];
      s_wdata = sh_r;
    end else if (state_r == S_SW2) begin
      s_we    = 1'b1;
      s_waddr = hi_r[PW-1:0];
      s_wdata = sl_r;
    end
    i_raddr = s_rdata;
  end

  kdms_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_coord (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));
  kdms_ram #(.WIDTH(ID_W), .DEPTH(MAX_POINTS)) u_id (
    .clk(clk), .we(i_we), .waddr(pc_r[PW-1:0]), .wdata(in_id),
    .raddr(i_raddr), .rdata(i_rdata));
  kdms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  // shared multiplier
  logic signed [SW-1:0] mul_a;
  logic signed [QW:0]   mul_b;
  always_comb begin
    case (state_r)
      S_VN:    begin mul_a = SW'($signed({1'b0, n_r})); mul_b = sumsq_r; end
      S_VS2:   begin mul_a = sum_r; mul_b = (QW+1)'(sum_r); end
      default: begin mul_a = SW'(c_rdata); mul_b = (QW+1)'(c_rdata); end
    endcase
  end

  logic signed [PRW-1:0] score;
  logic signed [MED_W-1:0] x2;
  logic lo_cond;
  logic [CNTW-1:0] k1, k2;
  assign score   = t_r - prod_r;
  assign x2      = {c_rdata, 1'b0};
  assign lo_cond = pass_r ? (x2 <= med2_r) : (x2 < med2_r);
  assign k2      = n_r >> 1;
  assign k1      = n_r[0] ? k2 : k2 - CNTW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      dimcfg_r    <= CFG_W'(DIM_RST);
      pc_r        <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_tvalid) dimcfg_r <= cfg_tdata[CFG_W-1:0];
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (!full) begin
              if (c_last || in_tlast) begin
                if (!c_last) begin
                  fill_d_r <= c_sel + DW'(1);
                  state_r  <= S_FILL;
                end else begin
                  pc_r <= pc_r + CNTW'(1);
                  ci_r <= '0;
                  n_r  <= pc_r + CNTW'(1);
                  if (in_tlast) state_r <= S_VINIT;
                end
              end else begin
                ci_r <= c_sel + DW'(1);
              end
            end else if (in_tlast) begin
              n_r     <= pc_r;
              state_r <= S_VINIT;
            end
          end
        end
        S_FILL: begin
          if (fill_d_r == dims_m1) begin
            pc_r    <= pc_r + CNTW'(1);
            ci_r    <= '0;
            n_r     <= pc_r + CNTW'(1);
            state_r <= S_VINIT;
          end else begin
            fill_d_r <= fill_d_r + DW'(1);
          end
        end
        S_VINIT: begin
          d_r <= '0; i_r <= '0; sum_r <= '0; sumsq_r <= '0;
          state_r <= S_VRD;
        end
        S_VRD: state_r <= S_VSQ;
        S_VSQ: begin
          x_r     <= c_rdata;
          prod_r  <= PRW'(mul_a * mul_b);
          state_r <= S_VACC;
        end
        S_VACC: begin
          sum_r   <= sum_r + SW'(x_r);
          sumsq_r <= sumsq_r + (QW+1)'(prod_r);
          i_r     <= i_r + CNTW'(1);
          state_r <= (i_r == n_m1) ? S_VN : S_VRD;
        end
        S_VN: begin
          prod_r  <= PRW'(mul_a * mul_b);
          state_r <= S_VS2;
        end
        S_VS2: begin
          t_r     <= prod_r;
          prod_r  <= PRW'(mul_a * mul_b);
          state_r <= S_VCMP;
        end
        S_VCMP: begin
          if (d_r == '0 || score > best_r) begin
            best_r <= score;
            bd_r   <= d_r;
          end
          d_r <= d_r + DW'(1);
          i_r <= '0; sum_r <= '0; sumsq_r <= '0;
          state_r <= (d_r == dims_m1) ? S_MINIT : S_VRD;
        end
        S_MINIT: begin
          i_r     <= '0;
          state_r <= S_MRI;
        end
        S_MRI: state_r <= S_MLI;
        S_MLI: begin
          xi_r <= c_rdata; j_r <= '0; cnt_lt_r <= '0; cnt_le_r <= '0;
          state_r <= S_MRJ;
        end
        S_MRJ: state_r <= S_MCJ;
        S_MCJ: begin
          if (c_rdata < xi_r)  cnt_lt_r <= cnt_lt_r + CNTW'(1);
          if (c_rdata <= xi_r) cnt_le_r <= cnt_le_r + CNTW'(1);
          j_r     <= j_r + CNTW'(1);
          state_r <= (j_r == n_m1) ? S_MSEL : S_MRJ;
        end
        S_MSEL: begin
          if (cnt_lt_r <= k1 && k1 < cnt_le_r) mlo_r <= xi_r;
          if (cnt_lt_r <= k2 && k2 < cnt_le_r) mhi_r <= xi_r;
          i_r     <= i_r + CNTW'(1);
          state_r <= (i_r == n_m1) ? S_MMED : S_MRI;
        end
        S_MMED: begin
          med2_r  <= MED_W'(mlo_r) + MED_W'(mhi_r);
          i_r     <= '0;
          state_r <= S_SINIT;
        end
        S_SINIT: begin
          i_r     <= i_r + CNTW'(1);
          state_r <= (i_r == n_m1) ? S_PST : S_SINIT;
        end
        S_PST: begin
          pass_r  <= 1'b0;
          lo_r    <= '0;
          hi_r    <= $signed({1'b0, n_m1});
          state_r <= S_LORD;
        end
        S_LORD:  state_r <= (lo_r >= n_r) ? S_HIRD : S_LOCRD;
        S_LOCRD: begin
          sl_r    <= s_rdata;
          state_r <= S_LOCMP;
        end
        S_LOCMP: begin
          if (lo_cond) begin
            lo_r    <= lo_r + CNTW'(1);
            state_r <= S_LORD;
          end else begin
            state_r <= S_HIRD;
          end
        end
        S_HIRD:  state_r <= (hi_r < 0) ? S_CHK : S_HICRD;
        S_HICRD: begin
          sh_r    <= s_rdata;
          state_r <= S_HICMP;
        end
        S_HICMP: begin
          if (!lo_cond) begin
            hi_r    <= hi_r - (CNTW+1)'(1);
            state_r <= S_HIRD;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (lo_gt_hi) begin
            if (!pass_r) begin
              br1_r   <= lo_r;
              pass_r  <= 1'b1;
              hi_r    <= $signed({1'b0, n_m1});
              state_r <= S_LORD;
            end else begin
              br2_r   <= lo_r;
              state_r <= S_OINIT;
            end
          end else begin
            state_r <= S_SW2;
          end
        end
        S_SW2: begin
          lo_r    <= lo_r + CNTW'(1);
          hi_r    <= hi_r - (CNTW+1)'(1);
          state_r <= S_LORD;
        end
        S_OINIT: begin
          if (br1_r > k2) lowc_r <= LOWC_W'(br1_r);
          else if (br2_r < k2) lowc_r <= LOWC_W'(br2_r);
          else lowc_r <= LOWC_W'(k2);
          i_r     <= '0;
          state_r <= S_ORD;
        end
        S_ORD: state_r <= S_OID;
        S_OID: state_r <= S_OSET;
        S_OSET: begin
          out_id_r    <= i_rdata;
          out_last_r  <= (i_r == n_m1);
          out_valid_r <= 1'b1;
          state_r     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              pc_r    <= '0;
              ci_r    <= '0;
              state_r <= S_LOAD;
            end else begin
              i_r     <= i_r + CNTW'(1);
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, lowc_r, med2_r, SDIM_W'(bd_r), out_id_r};
endmodule
